// ===== rtl/osf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the observer state feedback block: gain table,
// control word layout and the microcode program. No dependencies.
package osf_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IO_W          = 32;
	localparam int KI_W          = 17;
	localparam int CLAMP_W       = 31;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 31;

	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ON    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT = 2'd2;

	// Decimal gains in units of 1e-8: F row-major with G and B per row,
	// then K1..K5, then the integrator gain default.
	localparam int     NGAIN     = 24;
	localparam int     NGAIN_FIX = 23;
	localparam int     KI_IDX    = 23;
	localparam longint DEC_SCALE = 64'd100000000;
	localparam longint GAIN_DEC [NGAIN] = '{
		44058870,   -325957,   957373,  55941130,  2325957,    93307,
		 4789254,  12823289, 91391248,  -4789254, 87176711, 13676758,
		 1612799, -10614460, 75147729,  -1612799, 10614460, 24852271,
		12500000, 100000000, -170465281, -33244746, -85195044,
		 5555128
	};

	// Round a decimal gain to nearest at frac fraction bits, ties away from zero.
	function automatic longint gain_q(input int idx, input int frac);
		longint d;
		longint m;
		longint q;
		d = GAIN_DEC[idx];
		m = (d < 0) ? -d : d;
		q = ((m << frac) + DEC_SCALE / 2) / DEC_SCALE;
		return (d < 0) ? -q : q;
	endfunction

	localparam int STEP_W = 5;
	localparam int COEF_W = 5;
	localparam logic [COEF_W-1:0] COEF_KI = 5'd23;

	typedef enum logic [1:0] {
		COND_NONE = 2'd0,
		COND_IN   = 2'd1,
		COND_OUT  = 2'd2
	} cond_t;

	typedef enum logic [3:0] {
		SRC_E1    = 4'd0,
		SRC_E2    = 4'd1,
		SRC_E3    = 4'd2,
		SRC_ANG   = 4'd3,
		SRC_RATE  = 4'd4,
		SRC_DRV   = 4'd5,
		SRC_SP    = 4'd6,
		SRC_ERR   = 4'd7,
		SRC_INTEG = 4'd8
	} src_t;

	typedef enum logic [1:0] {
		ACC_FIRST = 2'd0,
		ACC_ADD   = 2'd1,
		ACC_INTEG = 2'd2
	} acc_mode_t;

	typedef enum logic [2:0] {
		DST_NONE  = 3'd0,
		DST_T1    = 3'd1,
		DST_T2    = 3'd2,
		DST_E3    = 3'd3,
		DST_INTEG = 3'd4,
		DST_OUT   = 3'd5
	} dest_t;

	typedef struct packed {
		cond_t             cond;
		logic              last;
		logic              mul_en;
		src_t              src;
		logic [COEF_W-1:0] coef;
		acc_mode_t         mode;
		dest_t             dest;
		logic              err_en;
		logic              commit_en;
	} ucode_t;

	// Accumulate-stage part of a control word, registered so that it acts in the cycle after the multiply.
	typedef struct packed {
		logic      mul_en;
		acc_mode_t mode;
		dest_t     dest;
	} acc_ctrl_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '{COND_NONE, 1'b1, 1'b0, SRC_E1, 5'd0, ACC_FIRST, DST_NONE, 1'b0, 1'b0};
		case (step)
			// wait for a request and latch it
			5'd0:  w = '{COND_IN,   1'b0, 1'b0, SRC_E1,    5'd0,  ACC_FIRST, DST_NONE,  1'b0, 1'b0};
			// observer row 1
			5'd1:  w = '{COND_NONE, 1'b0, 1'b1, SRC_E1,    5'd0,  ACC_FIRST, DST_NONE,  1'b0, 1'b0};
			5'd2:  w = '{COND_NONE, 1'b0, 1'b1, SRC_E2,    5'd1,  ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd3:  w = '{COND_NONE, 1'b0, 1'b1, SRC_E3,    5'd2,  ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd4:  w = '{COND_NONE, 1'b0, 1'b1, SRC_ANG,   5'd3,  ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd5:  w = '{COND_NONE, 1'b0, 1'b1, SRC_RATE,  5'd4,  ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd6:  w = '{COND_NONE, 1'b0, 1'b1, SRC_DRV,   5'd5,  ACC_ADD,   DST_T1,    1'b0, 1'b0};
			// observer row 2; the error uses the new first estimate
			5'd7:  w = '{COND_NONE, 1'b0, 1'b1, SRC_E1,    5'd6,  ACC_FIRST, DST_NONE,  1'b0, 1'b0};
			5'd8:  w = '{COND_NONE, 1'b0, 1'b1, SRC_E2,    5'd7,  ACC_ADD,   DST_NONE,  1'b1, 1'b0};
			5'd9:  w = '{COND_NONE, 1'b0, 1'b1, SRC_E3,    5'd8,  ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd10: w = '{COND_NONE, 1'b0, 1'b1, SRC_ANG,   5'd9,  ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd11: w = '{COND_NONE, 1'b0, 1'b1, SRC_RATE,  5'd10, ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd12: w = '{COND_NONE, 1'b0, 1'b1, SRC_DRV,   5'd11, ACC_ADD,   DST_T2,    1'b0, 1'b0};
			// observer row 3
			5'd13: w = '{COND_NONE, 1'b0, 1'b1, SRC_E1,    5'd12, ACC_FIRST, DST_NONE,  1'b0, 1'b0};
			5'd14: w = '{COND_NONE, 1'b0, 1'b1, SRC_E2,    5'd13, ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd15: w = '{COND_NONE, 1'b0, 1'b1, SRC_E3,    5'd14, ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd16: w = '{COND_NONE, 1'b0, 1'b1, SRC_ANG,   5'd15, ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd17: w = '{COND_NONE, 1'b0, 1'b1, SRC_RATE,  5'd16, ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd18: w = '{COND_NONE, 1'b0, 1'b1, SRC_DRV,   5'd17, ACC_ADD,   DST_E3,    1'b0, 1'b0};
			// integrator, and commit the first two estimates
			5'd19: w = '{COND_NONE, 1'b0, 1'b1, SRC_ERR,   COEF_KI, ACC_INTEG, DST_INTEG, 1'b0, 1'b1};
			// state feedback
			5'd20: w = '{COND_NONE, 1'b0, 1'b1, SRC_SP,    5'd18, ACC_FIRST, DST_NONE,  1'b0, 1'b0};
			5'd21: w = '{COND_NONE, 1'b0, 1'b1, SRC_INTEG, 5'd19, ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd22: w = '{COND_NONE, 1'b0, 1'b1, SRC_E1,    5'd20, ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd23: w = '{COND_NONE, 1'b0, 1'b1, SRC_E2,    5'd21, ACC_ADD,   DST_NONE,  1'b0, 1'b0};
			5'd24: w = '{COND_OUT,  1'b1, 1'b1, SRC_E3,    5'd22, ACC_ADD,   DST_OUT,   1'b0, 1'b0};
			default: w = '{COND_NONE, 1'b1, 1'b0, SRC_E1, 5'd0, ACC_FIRST, DST_NONE, 1'b0, 1'b0};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/osf_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the observer state feedback block: sample requests
// in, command results out. Depends on osf_pkg.
interface osf_in_if import osf_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IO_W-1:0] angle;
	logic signed [IO_W-1:0] rate;
	logic signed [IO_W-1:0] target;
	logic signed [IO_W-1:0] drive_level;

	modport source (output valid, output angle, output rate, output target,
		output drive_level, input ready);
	modport sink (input valid, input angle, input rate, input target,
		input drive_level, output ready);
endinterface

interface osf_out_if import osf_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IO_W-1:0] command;

	modport source (output valid, output command, input ready);
	modport sink (input valid, input command, output ready);
endinterface

// ===== rtl/observer_state_feedback_axis_top.sv =====
`timescale 1ns / 1ps
// Observer with state feedback and integral action for one attitude axis.
// Each request runs the 25-step microcode program: all 24 products through one
// shared multiplier and accumulator, the command registered after the last sum.
// The next request is taken at step 0; the last step holds while the output is full.
// Reset (arst_n low, asynchronous): estimates and integrator clear, registers
// take their defaults, the output empties and the sequencer waits at step 0.
module observer_state_feedback_axis_top import osf_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	osf_in_if.sink                in_ch,
	osf_out_if.source             out_ch
);

	// Coefficient width: gains stay below 2.0, the integrator gain is 17 bits unsigned.
	localparam int CW = (FRAC_BITS + 2 > KI_W + 1) ? FRAC_BITS + 2 : KI_W + 1;
	localparam int PW = WORD_BITS + CW;
	localparam int XW = (WORD_BITS > IO_W) ? WORD_BITS : IO_W;
	localparam int LW = ((WORD_BITS > CLAMP_W) ? WORD_BITS : CLAMP_W) + 2;

	localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [KI_W-1:0]    KI_RST    = KI_W'(gain_q(KI_IDX, FRAC_BITS));
	localparam logic [CLAMP_W-1:0] LIMIT_RST = CLAMP_W'(65536);

	// Saturate a shifted product to the word.
	function automatic logic signed [WORD_BITS-1:0] sat_prod(input logic signed [PW-1:0] v);
		logic signed [WORD_BITS-1:0] r;
		if ((&v[PW-1:WORD_BITS-1]) || !(|v[PW-1:WORD_BITS-1])) r = v[WORD_BITS-1:0];
		else if (v[PW-1]) r = W_MIN;
		else r = W_MAX;
		return r;
	endfunction

	// Saturate a one-bit-grown sum to the word.
	function automatic logic signed [WORD_BITS-1:0] sat_sum(input logic [WORD_BITS:0] s);
		logic signed [WORD_BITS-1:0] r;
		if (s[WORD_BITS] != s[WORD_BITS-1]) r = s[WORD_BITS] ? W_MIN : W_MAX;
		else r = s[WORD_BITS-1:0];
		return r;
	endfunction

	// Bring a 32-bit port value into the word, saturating if the word is narrower.
	function automatic logic signed [WORD_BITS-1:0] in_sat(input logic signed [IO_W-1:0] x);
		logic signed [XW-1:0]        xe;
		logic signed [WORD_BITS-1:0] r;
		xe = XW'(x);
		if ((&xe[XW-1:WORD_BITS-1]) || !(|xe[XW-1:WORD_BITS-1])) r = xe[WORD_BITS-1:0];
		else if (xe[XW-1]) r = W_MIN;
		else r = W_MAX;
		return r;
	endfunction

	// Fixed gains, worked out at elaboration for this fraction width.
	logic signed [CW-1:0] gain_w [NGAIN_FIX];
	for (genvar g = 0; g < NGAIN_FIX; g++) begin : g_gain
		assign gain_w[g] = CW'(gain_q(g, FRAC_BITS));
	end

	// Configuration registers.
	logic [KI_W-1:0]    integ_gain_q;
	logic               clamp_on_q;
	logic [CLAMP_W-1:0] clamp_limit_q;

	// Sequencer.
	logic [STEP_W-1:0] step_q;
	ucode_t            uw;
	logic              go;
	logic              issue;
	logic              in_acc;
	acc_ctrl_t         ctrl_s1;

	// Latched request and state.
	logic signed [WORD_BITS-1:0] ang_q, rate_q, sp_q, drv_q;
	logic signed [WORD_BITS-1:0] est1_q, est2_q, est3_q, integ_q;
	logic signed [WORD_BITS-1:0] t1_q, t2_q, err_q, acc_q;

	// Datapath.
	logic signed [WORD_BITS-1:0] op_data;
	logic signed [CW-1:0]        op_coef;
	logic signed [PW-1:0]        prod_s1;
	logic signed [PW-1:0]        p_sh;
	logic signed [WORD_BITS-1:0] p_sat;
	logic signed [WORD_BITS-1:0] base;
	logic signed [WORD_BITS-1:0] sum;
	logic signed [LW-1:0]        sum_e;
	logic signed [LW-1:0]        lim_e;
	logic signed [WORD_BITS-1:0] acc_d;

	logic                   out_valid_q;
	logic signed [IO_W-1:0] cmd_q;

	// Fetch the control word of the current step.
	assign uw = ucode_rom(step_q);

	// Step 0 waits for a request; the last step waits until the output is free.
	always_comb begin
		case (uw.cond)
			COND_NONE: go = 1'b1;
			COND_IN:   go = in_ch.valid;
			COND_OUT:  go = !out_valid_q || out_ch.ready;
			default:   go = 1'b1;
		endcase
	end

	assign in_ch.ready = (uw.cond == COND_IN);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign issue       = go && uw.mul_en;

	// Select the multiplier operands.
	always_comb begin
		case (uw.src)
			SRC_E1:    op_data = est1_q;
			SRC_E2:    op_data = est2_q;
			SRC_E3:    op_data = est3_q;
			SRC_ANG:   op_data = ang_q;
			SRC_RATE:  op_data = rate_q;
			SRC_DRV:   op_data = drv_q;
			SRC_SP:    op_data = sp_q;
			SRC_ERR:   op_data = err_q;
			SRC_INTEG: op_data = integ_q;
			default:   op_data = '0;
		endcase
	end

	always_comb begin
		if (uw.coef == COEF_KI) op_coef = CW'({1'b0, integ_gain_q});
		else op_coef = gain_w[uw.coef];
	end

	// Accumulate stage: floor-shift and saturate the product, then load it or add it with saturation.
	// The integrator step adds onto the stored integrator and applies the clamp when it is on.
	always_comb begin
		p_sh  = prod_s1 >>> FRAC_BITS;
		p_sat = sat_prod(p_sh);
		base  = (ctrl_s1.mode == ACC_INTEG) ? integ_q : acc_q;
		if (ctrl_s1.mode == ACC_FIRST) sum = p_sat;
		else sum = sat_sum({base[WORD_BITS-1], base} + {p_sat[WORD_BITS-1], p_sat});
		sum_e = LW'(sum);
		lim_e = LW'({1'b0, clamp_limit_q});
		acc_d = sum;
		if (ctrl_s1.mode == ACC_INTEG && clamp_on_q) begin
			if (sum_e > lim_e) acc_d = WORD_BITS'(lim_e);
			else if (sum_e < -lim_e) acc_d = WORD_BITS'(-lim_e);
		end
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= '0;
			ctrl_s1       <= '{mul_en: 1'b0, mode: ACC_FIRST, dest: DST_NONE};
			out_valid_q   <= 1'b0;
			est1_q        <= '0;
			est2_q        <= '0;
			est3_q        <= '0;
			integ_q       <= '0;
			integ_gain_q  <= KI_RST;
			clamp_on_q    <= 1'b0;
			clamp_limit_q <= LIMIT_RST;
		end else begin
			// Advance, jump back after the last step, or hold on an unmet condition.
			if (go) step_q <= uw.last ? '0 : step_q + STEP_W'(1);
			ctrl_s1 <= '{mul_en: issue, mode: uw.mode, dest: uw.dest};

			// Commit the first two estimates once row 3 has read the old ones.
			if (go && uw.commit_en) begin
				est1_q <= t1_q;
				est2_q <= t2_q;
			end
			if (ctrl_s1.mul_en && ctrl_s1.dest == DST_E3) est3_q <= acc_d;
			if (ctrl_s1.mul_en && ctrl_s1.dest == DST_INTEG) integ_q <= acc_d;

			// Output register: fill on the final accumulate, drop when taken.
			if (ctrl_s1.mul_en && ctrl_s1.dest == DST_OUT) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_idx)
					REG_INTEG_GAIN:  integ_gain_q  <= cfg_data[KI_W-1:0];
					REG_CLAMP_ON:    clamp_on_q    <= cfg_data[0];
					REG_CLAMP_LIMIT: clamp_limit_q <= cfg_data[CLAMP_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ang_q  <= in_sat(in_ch.angle);
			rate_q <= in_sat(in_ch.rate);
			sp_q   <= in_sat(in_ch.target);
			drv_q  <= in_sat(in_ch.drive_level);
		end
		if (issue) prod_s1 <= PW'(op_data) * PW'(op_coef);
		if (ctrl_s1.mul_en) acc_q <= acc_d;
		if (ctrl_s1.mul_en && ctrl_s1.dest == DST_T1) t1_q <= acc_d;
		if (ctrl_s1.mul_en && ctrl_s1.dest == DST_T2) t2_q <= acc_d;
		// Error against the new first estimate, saturated.
		if (go && uw.err_en) err_q <= sat_sum({sp_q[WORD_BITS-1], sp_q} - {t1_q[WORD_BITS-1], t1_q});
		if (ctrl_s1.mul_en && ctrl_s1.dest == DST_OUT) cmd_q <= IO_W'(acc_d);
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.command = cmd_q;

endmodule

// ===== rtl/osf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the observer state feedback block and the bind that
// attaches them to the top level. Depends on osf_pkg and the channel interfaces.
module osf_checker import osf_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic [IO_W-1:0] command
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(command))
		else $error("result changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("new request taken while the program runs");

	a_result_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready, 2))
		else $error("result appeared without a finished program run");

endmodule

bind observer_state_feedback_axis_top osf_checker u_osf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.command   (out_ch.command)
);
